// File: hdl/tseg_pkg.sv
// Package for the trend segmenter: segment kind codes, register indexes
// and the sizing of the result queue. No dependencies.
`timescale 1ns / 1ps

package tseg_pkg;

  typedef enum logic [1:0] {
    KindStable  = 2'd0,
    KindAscend  = 2'd1,
    KindDescend = 2'd2
  } kind_e;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMaxDev    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartTime = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval  = 2'd2;

  localparam int CfgDataW  = 64;
  localparam int TimeW     = 64;
  localparam int IntervalW = 32;
  localparam int DevW      = 16;

  localparam logic [DevW-1:0]      MaxDevReset   = 16'd4;
  localparam logic [IntervalW-1:0] IntervalReset = 32'd1000;

  // Result queue: an item may push two words, so room for two is required.
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

endpackage

// File: hdl/trend_segmenter_top.sv
// Trend segmenter top level: classifier, segment state and result queue.
// Depends on tseg_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: one raw sample word per handshake (in_valid_i/in_ready_o),
//   with is_last_i marking the final sample of a window. Output channel: one
//   segment word per handshake (out_valid_o/out_ready_i).
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
//   block is idle; index 0 is the stability limit, 1 the window start time,
//   2 the sample interval. Other indexes are ignored.
//   Each sample is classified and the segment state updated in the cycle it
//   is accepted; the zero, one or two segment words it closes enter a
//   four-word result queue, which presents them on the output in order.
//   Throughput is one sample per cycle while the receiver keeps up and samples
//   produce at most one word on average; the queue depth and the single output
//   port set this. A sample is accepted only while the queue has room for two
//   words. When the receiver stalls, the queue fills and in_ready_o drops; no
//   word is lost. Reset empties the queue, closes any open window and restores
//   the register defaults (limit 4, start time 0, interval 1000).
module trend_segmenter_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tseg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tseg_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            raw_sample_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        segment_kind_o,
  output logic [SAMPLE_BITS-1:0]            start_raw_o,
  output logic [SAMPLE_BITS-1:0]            end_raw_o,
  output logic [tseg_pkg::TimeW-1:0]        start_time_o,
  output logic [tseg_pkg::TimeW-1:0]        end_time_o,
  output logic                              last_of_run_o
);

  localparam int S    = SAMPLE_BITS;
  localparam int CmpW = ((S + 1 > tseg_pkg::DevW) ? S + 1 : tseg_pkg::DevW) + 1;

  typedef struct packed {
    tseg_pkg::kind_e                 kind;
    logic [S-1:0]                    start_raw;
    logic [S-1:0]                    end_raw;
    logic [tseg_pkg::TimeW-1:0]      start_time;
    logic [tseg_pkg::TimeW-1:0]      end_time;
    logic                            last;
  } seg_t;

  // Configuration registers.
  logic [tseg_pkg::DevW-1:0]      max_dev_q;
  logic [tseg_pkg::TimeW-1:0]     win_start_q;
  logic [tseg_pkg::IntervalW-1:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev_q   <= tseg_pkg::MaxDevReset;
      win_start_q <= '0;
      interval_q  <= tseg_pkg::IntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tseg_pkg::CfgMaxDev:    max_dev_q   <= cfg_wdata_i[tseg_pkg::DevW-1:0];
        tseg_pkg::CfgStartTime: win_start_q <= cfg_wdata_i;
        tseg_pkg::CfgInterval:  interval_q  <= cfg_wdata_i[tseg_pkg::IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // Open segment state.
  logic                       in_window_q;
  tseg_pkg::kind_e            seg_kind_q;
  logic [S-1:0]               seg_start_raw_q;
  logic [tseg_pkg::TimeW-1:0] seg_start_time_q;
  logic [tseg_pkg::TimeW-1:0] cur_time_q;

  // Result queue.
  seg_t                           fifo_q [tseg_pkg::FifoDepth];
  logic [tseg_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [tseg_pkg::CntW-1:0]      cnt_q;

  logic in_acc, out_pop;
  assign in_ready_o  = (cnt_q <= tseg_pkg::CntW'(tseg_pkg::FifoDepth - 2));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_pop     = out_valid_o && out_ready_i;

  // A window opens with a stable segment at the configured start time.
  tseg_pkg::kind_e            base_kind;
  logic [S-1:0]               base_raw;
  logic [tseg_pkg::TimeW-1:0] base_time, cur_time;
  logic signed [S:0]          dev;
  logic [S:0]                 mag;
  tseg_pkg::kind_e            cls;
  logic                       changed, emit_closed;
  seg_t                       closed_seg, final_seg;

  always_comb begin
    if (in_window_q) begin
      base_kind = seg_kind_q;
      base_raw  = seg_start_raw_q;
      base_time = seg_start_time_q;
      cur_time  = cur_time_q + {{(tseg_pkg::TimeW - tseg_pkg::IntervalW){1'b0}}, interval_q};
    end else begin
      base_kind = tseg_pkg::KindStable;
      base_raw  = raw_sample_i;
      base_time = win_start_q;
      cur_time  = win_start_q;
    end

    dev = $signed({1'b0, raw_sample_i}) - $signed({1'b0, base_raw});
    mag = dev[S] ? $unsigned(-dev) : $unsigned(dev);

    // A deviation equal to the limit already counts as a trend.
    if ({{(CmpW - S - 1){1'b0}}, mag} < {{(CmpW - tseg_pkg::DevW){1'b0}}, max_dev_q}) begin
      cls = tseg_pkg::KindStable;
    end else if (!dev[S]) begin
      cls = tseg_pkg::KindAscend;
    end else begin
      cls = tseg_pkg::KindDescend;
    end

    changed     = (cls != base_kind);
    emit_closed = changed && (cur_time != base_time);

    closed_seg.kind       = base_kind;
    closed_seg.start_raw  = base_raw;
    closed_seg.end_raw    = raw_sample_i;
    closed_seg.start_time = base_time;
    closed_seg.end_time   = cur_time;
    closed_seg.last       = 1'b0;

    final_seg.kind       = cls;
    final_seg.start_raw  = changed ? raw_sample_i : base_raw;
    final_seg.end_raw    = raw_sample_i;
    final_seg.start_time = changed ? cur_time : base_time;
    final_seg.end_time   = cur_time;
    final_seg.last       = 1'b1;
  end

  logic [1:0]                push_n;
  logic [tseg_pkg::CntW-1:0] cnt_d;
  assign push_n = in_acc ? ({1'b0, emit_closed} + {1'b0, is_last_i}) : 2'd0;
  assign cnt_d  = cnt_q + tseg_pkg::CntW'(push_n) - tseg_pkg::CntW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_window_q      <= 1'b0;
      seg_kind_q       <= tseg_pkg::KindStable;
      seg_start_raw_q  <= '0;
      seg_start_time_q <= '0;
      cur_time_q       <= '0;
      wr_ptr_q         <= '0;
      rd_ptr_q         <= '0;
      cnt_q            <= '0;
    end else begin
      if (in_acc) begin
        in_window_q      <= !is_last_i;
        seg_kind_q       <= cls;
        seg_start_raw_q  <= final_seg.start_raw;
        seg_start_time_q <= final_seg.start_time;
        cur_time_q       <= cur_time;
        wr_ptr_q         <= wr_ptr_q + tseg_pkg::PtrW'(push_n);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + tseg_pkg::PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage: the closed word goes first, the final word after it.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit_closed) begin
      fifo_q[wr_ptr_q] <= closed_seg;
    end
    if (in_acc && is_last_i) begin
      fifo_q[wr_ptr_q + tseg_pkg::PtrW'(emit_closed)] <= final_seg;
    end
  end

  seg_t head;
  assign head           = fifo_q[rd_ptr_q];
  assign segment_kind_o = head.kind;
  assign start_raw_o    = head.start_raw;
  assign end_raw_o      = head.end_raw;
  assign start_time_o   = head.start_time;
  assign end_time_o     = head.end_time;
  assign last_of_run_o  = head.last;

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tseg_pkg::CntW'(tseg_pkg::FifoDepth))
    else $error("result queue overflow");

  // A last sample always leaves a word behind and closes the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last_i && !out_pop |=> cnt_q > $past(cnt_q) && !in_window_q)
    else $error("last sample did not produce a final segment");

  // A non-last sample keeps the window open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_last_i |=> in_window_q)
    else $error("window closed without a last sample");

  // Count and pointers stay consistent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == tseg_pkg::CntW'(tseg_pkg::FifoDepth)) || (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with fill count");

endmodule
